/* rtl/rgb555_color_blend_and_tone_assert.svh */
// ----------------------------------------------------------------------------
// RGB555 color transform assertion macros
// Shorthand for the clocked checks used in the RTL of the color transform.
// ----------------------------------------------------------------------------
`ifndef RGB555_COLOR_BLEND_AND_TONE_ASSERT_SVH
`define RGB555_COLOR_BLEND_AND_TONE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RGBBT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RGBBT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rgbbt_pkg.sv */
// ----------------------------------------------------------------------------
// RGB555 color transform package
// Register indexes, mode codes, weights and the stage payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbbt_pkg;

   localparam logic [2:0] CSR_MODE        = 3'd0;
   localparam logic [2:0] CSR_BLEND_COEFF = 3'd1;
   localparam logic [2:0] CSR_BLEND_COLOR = 3'd2;
   localparam logic [2:0] CSR_TONE_RED    = 3'd3;
   localparam logic [2:0] CSR_TONE_GREEN  = 3'd4;
   localparam logic [2:0] CSR_TONE_BLUE   = 3'd5;

   localparam logic [2:0] MODE_BLEND  = 3'd0;
   localparam logic [2:0] MODE_INVERT = 3'd1;
   localparam logic [2:0] MODE_GRAY   = 3'd2;
   localparam logic [2:0] MODE_RGRAY  = 3'd3;
   localparam logic [2:0] MODE_SEPIA  = 3'd4;
   localparam logic [2:0] MODE_TONE   = 3'd5;

   localparam logic [7:0] LUMA_W_RED   = 8'd76;
   localparam logic [7:0] LUMA_W_GREEN = 8'd151;
   localparam logic [7:0] LUMA_W_BLUE  = 8'd29;
   localparam logic [8:0] SEPIA_RED    = 9'd307;
   localparam logic [7:0] SEPIA_BLUE   = 8'd240;
   localparam logic [4:0] CHAN_MAX     = 5'd31;
   localparam logic [4:0] BLEND_FULL   = 5'd16;

   typedef struct packed {
      logic [2:0]  mode;
      logic [4:0]  blend_coeff;
      logic [14:0] blend_color;
      logic [15:0] tone_red;
      logic [15:0] tone_green;
      logic [15:0] tone_blue;
   } cfg_type;

   typedef struct packed {
      logic [15:0]       color;
      logic              last;
      logic [4:0]        luma;
      logic signed [9:0] bd_red;
      logic signed [9:0] bd_green;
      logic signed [9:0] bd_blue;
   } front_type;

   typedef struct packed {
      logic [15:0] color;
      logic        last;
      logic [14:0] blend;
      logic [4:0]  gray;
      logic [4:0]  rgray;
      logic [4:0]  sepia_red;
      logic [4:0]  sepia_blue;
      logic [4:0]  tone_red;
      logic [4:0]  tone_green;
      logic [4:0]  tone_blue;
   } mid_type;

   // Luma snapped to a coarse set of gray levels.
   function automatic logic [4:0] round_gray(input logic [4:0] y);
      logic [4:0] v;
      case (y) inside
         [5'd0:5'd4]:   v = 5'd0;
         [5'd5:5'd9]:   v = 5'd5;
         [5'd10:5'd14]: v = 5'd11;
         [5'd15:5'd19]: v = 5'd16;
         [5'd20:5'd24]: v = 5'd21;
         [5'd25:5'd29]: v = 5'd27;
         default:       v = 5'd31;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* rtl/rgbbt_chan_if.sv */
// ----------------------------------------------------------------------------
// RGB555 color transform channels
// Valid/ready channels for incoming palette words and transformed words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbbt_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] color_in;
   logic        is_last;
   modport source (output valid, output color_in, output is_last, input ready);
   modport sink (input valid, input color_in, input is_last, output ready);
endinterface

interface rgbbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] color_out;
   logic        last_out;
   modport source (output valid, output color_out, output last_out, input ready);
   modport sink (input valid, input color_out, input last_out, output ready);
endinterface

`default_nettype wire

/* rtl/rgbbt_front.sv */
// ----------------------------------------------------------------------------
// RGB555 color transform, first stage
// Computes the luma and the weighted blend differences of each channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbbt_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire logic                in_valid,
   input  wire logic [15:0]         in_color,
   input  wire logic                in_last,
   input  wire rgbbt_pkg::cfg_type  cfg,
   output logic                     out_valid,
   output rgbbt_pkg::front_type     out_data
);

   function automatic logic signed [9:0] blend_diff(input logic [4:0] c,
                                                    input logic [4:0] t,
                                                    input logic [4:0] k);
      logic signed [5:0] d;
      d = $signed({1'b0, t}) - $signed({1'b0, c});
      return $signed(10'(d)) * $signed({5'd0, k});
   endfunction

   logic                 valid_ff;
   rgbbt_pkg::front_type data_ff;
   rgbbt_pkg::front_type data_in;
   logic [4:0]           red;
   logic [4:0]           green;
   logic [4:0]           blue;
   logic [4:0]           weight;
   logic [12:0]          luma_sum;

   always_comb begin
      red    = in_color[4:0];
      green  = in_color[9:5];
      blue   = in_color[14:10];
      weight = (cfg.blend_coeff > rgbbt_pkg::BLEND_FULL) ? rgbbt_pkg::BLEND_FULL
                                                         : cfg.blend_coeff;
      luma_sum = 13'(red) * 13'(rgbbt_pkg::LUMA_W_RED)
               + 13'(green) * 13'(rgbbt_pkg::LUMA_W_GREEN)
               + 13'(blue) * 13'(rgbbt_pkg::LUMA_W_BLUE);
      data_in.color    = in_color;
      data_in.last     = in_last;
      data_in.luma     = luma_sum[12:8];
      data_in.bd_red   = blend_diff(red, cfg.blend_color[4:0], weight);
      data_in.bd_green = blend_diff(green, cfg.blend_color[9:5], weight);
      data_in.bd_blue  = blend_diff(blue, cfg.blend_color[14:10], weight);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/rgbbt_tone.sv */
// ----------------------------------------------------------------------------
// RGB555 color transform, second stage
// Finishes the blend and forms the gray, sepia and custom tone channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbbt_tone (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic                 in_valid,
   input  wire rgbbt_pkg::front_type in_data,
   input  wire rgbbt_pkg::cfg_type   cfg,
   output logic                      out_valid,
   output rgbbt_pkg::mid_type        out_data
);

   function automatic logic [4:0] blend_fix(input logic [4:0] c,
                                            input logic signed [9:0] d);
      logic signed [9:0] s;
      s = $signed({5'd0, c}) + (d >>> 4);
      return s[4:0];
   endfunction

   function automatic logic [4:0] tone_chan(input logic [15:0] tone,
                                            input logic [4:0] y);
      logic [20:0] p;
      p = 21'(tone) * 21'(y);
      return (p[15:8] > 8'(rgbbt_pkg::CHAN_MAX)) ? rgbbt_pkg::CHAN_MAX : p[12:8];
   endfunction

   logic               valid_ff;
   rgbbt_pkg::mid_type data_ff;
   rgbbt_pkg::mid_type data_in;
   logic [13:0]        sepia_r_prod;
   logic [12:0]        sepia_b_prod;

   always_comb begin
      sepia_r_prod = 14'(in_data.luma) * 14'(rgbbt_pkg::SEPIA_RED);
      sepia_b_prod = 13'(in_data.luma) * 13'(rgbbt_pkg::SEPIA_BLUE);
      data_in.color = in_data.color;
      data_in.last  = in_data.last;
      data_in.blend = {blend_fix(in_data.color[14:10], $signed(in_data.bd_blue)),
                       blend_fix(in_data.color[9:5], $signed(in_data.bd_green)),
                       blend_fix(in_data.color[4:0], $signed(in_data.bd_red))};
      data_in.gray  = in_data.luma;
      data_in.rgray = rgbbt_pkg::round_gray(in_data.luma);
      data_in.sepia_red = (sepia_r_prod[13:8] > 6'(rgbbt_pkg::CHAN_MAX))
                        ? rgbbt_pkg::CHAN_MAX : sepia_r_prod[12:8];
      data_in.sepia_blue = sepia_b_prod[12:8];
      data_in.tone_red   = tone_chan(cfg.tone_red, in_data.luma);
      data_in.tone_green = tone_chan(cfg.tone_green, in_data.luma);
      data_in.tone_blue  = tone_chan(cfg.tone_blue, in_data.luma);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/rgbbt_out.sv */
// ----------------------------------------------------------------------------
// RGB555 color transform, output stage
// Picks the word of the selected mode and holds it for the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbbt_out (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire logic               in_valid,
   input  wire rgbbt_pkg::mid_type in_data,
   input  wire rgbbt_pkg::cfg_type cfg,
   output logic                    out_valid,
   output logic [15:0]             out_color,
   output logic                    out_last
);

   logic        valid_ff;
   logic [15:0] color_ff;
   logic [15:0] color_in;
   logic        last_ff;

   always_comb begin
      case (cfg.mode)
         rgbbt_pkg::MODE_BLEND:  color_in = {1'b0, in_data.blend};
         rgbbt_pkg::MODE_INVERT: color_in = ~in_data.color;
         rgbbt_pkg::MODE_GRAY:
            color_in = {1'b0, in_data.gray, in_data.gray, in_data.gray};
         rgbbt_pkg::MODE_RGRAY:
            color_in = {1'b0, in_data.rgray, in_data.rgray, in_data.rgray};
         rgbbt_pkg::MODE_SEPIA:
            color_in = {1'b0, in_data.sepia_blue, in_data.gray, in_data.sepia_red};
         rgbbt_pkg::MODE_TONE:
            color_in = {1'b0, in_data.tone_blue, in_data.tone_green, in_data.tone_red};
         default:                color_in = 16'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         color_ff <= color_in;
         last_ff  <= in_data.last;
      end
   end

   assign out_valid = valid_ff;
   assign out_color = color_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

/* rtl/rgb555_color_blend_and_tone.sv */
// Each word on req_chan is one RGB555 palette color and yields exactly one
// transformed word on rsp_chan, in order, with is_last copied to last_out.
// The block is a three-register pipeline (luma and blend products, channel
// arithmetic, mode select into the output register); a new word can be taken
// every cycle while rsp_chan is not stalled. Each stage moves whenever the
// stage after it is empty or moving, so bubbles close up and req_chan stays
// ready while a finished word waits on rsp_chan as long as an earlier stage
// is free. Registers are written through the csr_ port and should only
// change while no word is in flight.
// ----------------------------------------------------------------------------
// RGB555 color transform top level
// Configuration registers, stage handshake and the three pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb555_color_blend_and_tone_assert.svh"

module rgb555_color_blend_and_tone (
   input  wire logic        clock,
   input  wire logic        reset,
   rgbbt_req_if.sink        req_chan,
   rgbbt_rsp_if.source      rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   rgbbt_pkg::cfg_type   cfg_ff;
   rgbbt_pkg::front_type front_data;
   rgbbt_pkg::mid_type   mid_data;
   logic                 front_valid;
   logic                 mid_valid;
   logic                 adv_front;
   logic                 adv_mid;
   logic                 adv_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rgbbt_pkg::CSR_MODE:        cfg_ff.mode        <= csr_wdata[2:0];
            rgbbt_pkg::CSR_BLEND_COEFF: cfg_ff.blend_coeff <= csr_wdata[4:0];
            rgbbt_pkg::CSR_BLEND_COLOR: cfg_ff.blend_color <= csr_wdata[14:0];
            rgbbt_pkg::CSR_TONE_RED:    cfg_ff.tone_red    <= csr_wdata;
            rgbbt_pkg::CSR_TONE_GREEN:  cfg_ff.tone_green  <= csr_wdata;
            rgbbt_pkg::CSR_TONE_BLUE:   cfg_ff.tone_blue   <= csr_wdata;
            default:                    cfg_ff             <= cfg_ff;
         endcase
      end
   end

   assign adv_out        = !rsp_chan.valid || rsp_chan.ready;
   assign adv_mid        = !mid_valid || adv_out;
   assign adv_front      = !front_valid || adv_mid;
   assign req_chan.ready = adv_front;

   rgbbt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .load      (adv_front),
      .in_valid  (req_chan.valid),
      .in_color  (req_chan.color_in),
      .in_last   (req_chan.is_last),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   rgbbt_tone u_tone (
      .clock     (clock),
      .reset     (reset),
      .load      (adv_mid),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .cfg       (cfg_ff),
      .out_valid (mid_valid),
      .out_data  (mid_data)
   );

   rgbbt_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (adv_out),
      .in_valid  (mid_valid),
      .in_data   (mid_data),
      .cfg       (cfg_ff),
      .out_valid (rsp_chan.valid),
      .out_color (rsp_chan.color_out),
      .out_last  (rsp_chan.last_out)
   );

   `RGBBT_ASSERT_IMP(a_full_blocks_input, clock, reset, front_valid && mid_valid && rsp_chan.valid && !rsp_chan.ready, !req_chan.ready, "Input taken while the whole pipeline is stalled.")
   `RGBBT_ASSERT_NXT(a_accept_fills_front, clock, reset, req_chan.valid && req_chan.ready, front_valid, "Accepted word did not reach the first stage.")
   `RGBBT_ASSERT_NXT(a_front_moves_on, clock, reset, front_valid && adv_mid, mid_valid, "First stage word lost on the way to the second stage.")
   `RGBBT_ASSERT_NXT(a_mid_moves_on, clock, reset, mid_valid && adv_out, rsp_chan.valid, "Second stage word lost on the way to the output.")

endmodule

`default_nettype wire
